@@ hw/rtl/ecps_pkg.sv @@
// ----------------------------------------------------------------------------
// ecps_pkg
// Shared types and fixed widths of the pointer smoother: datapath operation
// codes, controller states, status bundle and register indexes.
// ----------------------------------------------------------------------------
package ecps_pkg;

    localparam int SEMI_W  = 20;
    localparam int ALPHA_W = 17;
    localparam int DB_W    = 16;
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 2 * MUL_A_W + 1;
    localparam int SQ_W    = 64;
    localparam int SN_W    = 63;
    localparam int ROOT_W  = 32;
    localparam int DSH_W   = ROOT_W + MUL_B_W;
    localparam int REM_W   = DSH_W + 1;
    localparam int QUO_W   = SEMI_W + 1;
    localparam int MAG_LIM = 31;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = 3;

    localparam logic [CNT_W-1:0]   SQRT_LAST = 5'd31;
    localparam logic [CNT_W-1:0]   DIV_LAST  = 5'd20;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
    localparam logic [PROD_W-1:0]  ROUND_HALF = 60'd32768;

    localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_SEMI_X   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SEMI_Y   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ALPHA    = 3'd4;
    localparam logic [IDX_W-1:0] REG_DEADBAND = 3'd5;
    localparam logic [IDX_W-1:0] REG_SNAP     = 3'd6;

    typedef enum logic [5:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAG,
        OP_M_PB,
        OP_M_QA,
        OP_M_AB,
        OP_SQ_PL,
        OP_SQ_PH,
        OP_SQ_QL,
        OP_SQ_QH,
        OP_SQ_SL,
        OP_SQ_SH,
        OP_INSIDE,
        OP_TGT_IN,
        OP_SCALE,
        OP_SQ_XL,
        OP_SQ_XH,
        OP_SQ_YL,
        OP_SQ_YH,
        OP_N_FIN,
        OP_SQRT,
        OP_M_AX,
        OP_DIV_INIT,
        OP_DIV,
        OP_XOFF,
        OP_YOFF,
        OP_DEAD,
        OP_DIFF,
        OP_SM_X,
        OP_SM_Y,
        OP_SM_N,
        OP_FINISH
    } op_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_MAG,
        S_M_PB,
        S_M_QA,
        S_M_AB,
        S_SQ_PL,
        S_SQ_PH,
        S_SQ_QL,
        S_SQ_QH,
        S_SQ_SL,
        S_SQ_SH,
        S_INSIDE,
        S_BRANCH,
        S_SCALE,
        S_SQ_XL,
        S_SQ_XH,
        S_SQ_YL,
        S_SQ_YH,
        S_N_FIN,
        S_SQRT,
        S_M_AX,
        S_DIVX_INIT,
        S_DIVX,
        S_XOFF,
        S_DIVY_INIT,
        S_DIVY,
        S_YOFF,
        S_DEAD,
        S_DIFF,
        S_SM_X,
        S_SM_Y,
        S_SM_N,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic in_area;
        logic big;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/ecps_ctrl.sv @@
// ----------------------------------------------------------------------------
// ecps_ctrl
// Sequencer of the smoother: walks the datapath through the inside test,
// the square root and both divisions if clamped, and the smoothing steps.
// ----------------------------------------------------------------------------
module ecps_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ecps_pkg::sts_t   sts,
    output ecps_pkg::op_t    op
);
    import ecps_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             last_step;

    always_comb
    begin
        last_step = 1'b0;
        if (state_reg == S_SQRT)
        begin
            last_step = (cnt_reg == SQRT_LAST);
        end
        else if (state_reg == S_DIVX || state_reg == S_DIVY)
        begin
            last_step = (cnt_reg == DIV_LAST);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = S_MAG;
            S_MAG:       state_next = S_M_PB;
            S_M_PB:      state_next = S_M_QA;
            S_M_QA:      state_next = S_M_AB;
            S_M_AB:      state_next = S_SQ_PL;
            S_SQ_PL:     state_next = S_SQ_PH;
            S_SQ_PH:     state_next = S_SQ_QL;
            S_SQ_QL:     state_next = S_SQ_QH;
            S_SQ_QH:     state_next = S_SQ_SL;
            S_SQ_SL:     state_next = S_SQ_SH;
            S_SQ_SH:     state_next = S_INSIDE;
            S_INSIDE:    state_next = S_BRANCH;
            S_BRANCH:    state_next = sts.in_area ? S_DEAD : S_SCALE;
            S_SCALE:     if (!sts.big) state_next = S_SQ_XL;
            S_SQ_XL:     state_next = S_SQ_XH;
            S_SQ_XH:     state_next = S_SQ_YL;
            S_SQ_YL:     state_next = S_SQ_YH;
            S_SQ_YH:     state_next = S_N_FIN;
            S_N_FIN:     state_next = S_SQRT;
            S_SQRT:      if (last_step) state_next = S_M_AX;
            S_M_AX:      state_next = S_DIVX_INIT;
            S_DIVX_INIT: state_next = S_DIVX;
            S_DIVX:      if (last_step) state_next = S_XOFF;
            S_XOFF:      state_next = S_DIVY_INIT;
            S_DIVY_INIT: state_next = S_DIVY;
            S_DIVY:      if (last_step) state_next = S_YOFF;
            S_YOFF:      state_next = S_DEAD;
            S_DEAD:      state_next = S_DIFF;
            S_DIFF:      state_next = S_SM_X;
            S_SM_X:      state_next = S_SM_Y;
            S_SM_Y:      state_next = S_SM_N;
            S_SM_N:      state_next = S_FINISH;
            S_FINISH:    if (sts.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = '0;
        if ((state_reg == S_SQRT || state_reg == S_DIVX || state_reg == S_DIVY) && !last_step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        s_tready = (state_reg == S_IDLE);
        op       = OP_NONE;
        unique case (state_reg)
            S_IDLE:      op = s_tvalid ? OP_LOAD : OP_NONE;
            S_MAG:       op = OP_MAG;
            S_M_PB:      op = OP_M_PB;
            S_M_QA:      op = OP_M_QA;
            S_M_AB:      op = OP_M_AB;
            S_SQ_PL:     op = OP_SQ_PL;
            S_SQ_PH:     op = OP_SQ_PH;
            S_SQ_QL:     op = OP_SQ_QL;
            S_SQ_QH:     op = OP_SQ_QH;
            S_SQ_SL:     op = OP_SQ_SL;
            S_SQ_SH:     op = OP_SQ_SH;
            S_INSIDE:    op = OP_INSIDE;
            S_BRANCH:    op = sts.in_area ? OP_TGT_IN : OP_NONE;
            S_SCALE:     op = sts.big ? OP_SCALE : OP_NONE;
            S_SQ_XL:     op = OP_SQ_XL;
            S_SQ_XH:     op = OP_SQ_XH;
            S_SQ_YL:     op = OP_SQ_YL;
            S_SQ_YH:     op = OP_SQ_YH;
            S_N_FIN:     op = OP_N_FIN;
            S_SQRT:      op = OP_SQRT;
            S_M_AX:      op = OP_M_AX;
            S_DIVX_INIT: op = OP_DIV_INIT;
            S_DIVX:      op = OP_DIV;
            S_XOFF:      op = OP_XOFF;
            S_DIVY_INIT: op = OP_DIV_INIT;
            S_DIVY:      op = OP_DIV;
            S_YOFF:      op = OP_YOFF;
            S_DEAD:      op = OP_DEAD;
            S_DIFF:      op = OP_DIFF;
            S_SM_X:      op = OP_SM_X;
            S_SM_Y:      op = OP_SM_Y;
            S_SM_N:      op = OP_SM_N;
            S_FINISH:    op = sts.out_free ? OP_FINISH : OP_NONE;
            default:     op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/ecps_datapath.sv @@
// ----------------------------------------------------------------------------
// ecps_datapath
// Registers, shared 40x20 multiplier, square root and division steps,
// configuration registers and the result register of the smoother.
// ----------------------------------------------------------------------------
module ecps_datapath
#(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  ecps_pkg::op_t                                op,
    output ecps_pkg::sts_t                               sts,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]           s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]           m_tdata,
    output logic                                         m_tuser,
    input  logic                                         cfg_we,
    input  logic [ecps_pkg::IDX_W-1:0]                   cfg_index,
    input  logic [((COORD_WIDTH > ecps_pkg::SEMI_W) ?
                   COORD_WIDTH : ecps_pkg::SEMI_W)-1:0] cfg_data
);
    import ecps_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int MW = CW + 1;
    localparam int TW = ((CW > QUO_W) ? CW : QUO_W) + 1;
    localparam logic signed [TW-1:0] T_MAX = TW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [TW-1:0] T_MIN = -T_MAX - TW'(1);
    localparam logic [SEMI_W-1:0]  SEMI_X_RST = SEMI_W'(40 << FRAC_BITS);
    localparam logic [SEMI_W-1:0]  SEMI_Y_RST = SEMI_W'(30 << FRAC_BITS);
    localparam logic [ALPHA_W-1:0] ALPHA_RST  = ALPHA_W'(44657);
    localparam logic [DB_W-1:0]    DB_RST     = DB_W'(1 << (FRAC_BITS - 1));
    localparam logic [DB_W-1:0]    SNAP_RST   = DB_W'(((1 << FRAC_BITS) + 5) / 10);

    function automatic logic [MW-1:0] mag_m(input logic signed [MW-1:0] v);
        mag_m = v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    function automatic logic signed [CW-1:0] sat_t(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] c;
        c = v;
        if (v > T_MAX)
        begin
            c = T_MAX;
        end
        else if (v < T_MIN)
        begin
            c = T_MIN;
        end
        sat_t = c[CW-1:0];
    endfunction

    // configuration
    logic signed [CW-1:0] center_x_reg, center_y_reg;
    logic [SEMI_W-1:0]    semi_x_reg, semi_y_reg;
    logic [ALPHA_W-1:0]   alpha_reg;
    logic [DB_W-1:0]      deadband_reg, snap_reg;

    // tracked state
    logic signed [CW-1:0] hx_reg, hy_reg, fx_reg, fy_reg;
    logic signed [CW-1:0] hx_next, hy_next, fx_next, fy_next;

    // control flags
    logic inside_reg, inside_next;
    logic out_valid_reg, out_valid_next;

    // working registers
    logic signed [CW-1:0] px_reg, py_reg, px_next, py_next;
    logic signed [MW-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [MW-1:0]        mx_reg, my_reg, mx_next, my_next;
    logic                 pre_out_reg, pre_out_next;
    logic [MUL_A_W-1:0]   p_reg, q_reg, s_reg, p_next, q_next, s_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [PROD_W-1:0]    acc2_reg, acc2_next;
    logic [SN_W-1:0]      sn_reg, sn_next;
    logic [SQ_W-1:0]      res_reg, res_next;
    logic [SN_W-1:0]      sqb_reg, sqb_next;
    logic [ROOT_W-1:0]    r_reg, r_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DSH_W-1:0]     dsh_reg, dsh_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic                 clamped_reg, clamped_next;
    logic signed [CW-1:0] tx_reg, ty_reg, tx_next, ty_next;
    logic                 negx_reg, negy_reg, negx_next, negy_next;
    logic [MW-1:0]        dmx_reg, dmy_reg, dmx_next, dmy_next;
    logic signed [CW-1:0] nx_reg, ny_reg, nx_next, ny_next;
    logic signed [CW-1:0] ox_reg, oy_reg, ox_next, oy_next;
    logic                 oc_reg, oc_next;

    // combinational helpers
    logic [MUL_A_W-1:0]   mul_a, mx_a, my_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [ALPHA_W-1:0]   gain;
    logic [SQ_W-1:0]      sq_trial;
    logic                 sq_ge, div_ge, keep, snap_x, snap_y;
    logic [SEMI_W-1:0]    qsel_x, qsel_y;
    logic signed [TW-1:0] off_x, off_y, tsum_x, tsum_y;
    logic signed [MW-1:0] ex, ey, dfx, dfy, nsum_x, nsum_y, sx_d, sy_d;
    logic [MW-1:0]        step;
    logic [ACC_W-1:0]     s_sq;

    assign mx_a     = MUL_A_W'(mx_reg);
    assign my_a     = MUL_A_W'(my_reg);
    assign gain     = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign sq_trial = res_reg + SQ_W'(sqb_reg);
    assign sq_ge    = SQ_W'(sn_reg) >= sq_trial;
    assign div_ge   = rem_reg >= REM_W'(dsh_reg);
    assign qsel_x   = (quo_reg > QUO_W'(semi_x_reg)) ? semi_x_reg : quo_reg[SEMI_W-1:0];
    assign qsel_y   = (quo_reg > QUO_W'(semi_y_reg)) ? semi_y_reg : quo_reg[SEMI_W-1:0];
    assign off_x    = TW'(qsel_x);
    assign off_y    = TW'(qsel_y);
    assign tsum_x   = TW'(center_x_reg) + (dx_reg[MW-1] ? -off_x : off_x);
    assign tsum_y   = TW'(center_y_reg) + (dy_reg[MW-1] ? -off_y : off_y);
    assign ex       = MW'(tx_reg) - MW'(hx_reg);
    assign ey       = MW'(ty_reg) - MW'(hy_reg);
    assign keep     = (mag_m(ex) < MW'(deadband_reg)) && (mag_m(ey) < MW'(deadband_reg));
    assign dfx      = MW'(hx_reg) - MW'(fx_reg);
    assign dfy      = MW'(hy_reg) - MW'(fy_reg);
    assign step     = MW'((prod_reg + ROUND_HALF) >> 16);
    assign nsum_x   = negx_reg ? MW'(fx_reg) - $signed(step) : MW'(fx_reg) + $signed(step);
    assign nsum_y   = negy_reg ? MW'(fy_reg) - $signed(step) : MW'(fy_reg) + $signed(step);
    assign sx_d     = MW'(hx_reg) - MW'(nx_reg);
    assign sy_d     = MW'(hy_reg) - MW'(ny_reg);
    assign snap_x   = mag_m(sx_d) < MW'(snap_reg);
    assign snap_y   = mag_m(sy_d) < MW'(snap_reg);
    assign s_sq     = ACC_W'(acc2_reg) + (ACC_W'(prod_reg) << MUL_B_W);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_M_PB:  begin mul_a = mx_a; mul_b = semi_y_reg; end
            OP_M_QA:  begin mul_a = my_a; mul_b = semi_x_reg; end
            OP_M_AB:  begin mul_a = MUL_A_W'(semi_x_reg); mul_b = semi_y_reg; end
            OP_SQ_PL: begin mul_a = p_reg; mul_b = p_reg[MUL_B_W-1:0]; end
            OP_SQ_PH: begin mul_a = p_reg; mul_b = p_reg[MUL_A_W-1:MUL_B_W]; end
            OP_SQ_QL: begin mul_a = q_reg; mul_b = q_reg[MUL_B_W-1:0]; end
            OP_SQ_QH: begin mul_a = q_reg; mul_b = q_reg[MUL_A_W-1:MUL_B_W]; end
            OP_SQ_SL: begin mul_a = s_reg; mul_b = s_reg[MUL_B_W-1:0]; end
            OP_SQ_SH: begin mul_a = s_reg; mul_b = s_reg[MUL_A_W-1:MUL_B_W]; end
            OP_SQ_XL: begin mul_a = mx_a; mul_b = mx_a[MUL_B_W-1:0]; end
            OP_SQ_XH: begin mul_a = mx_a; mul_b = mx_a[MUL_A_W-1:MUL_B_W]; end
            OP_SQ_YL: begin mul_a = my_a; mul_b = my_a[MUL_B_W-1:0]; end
            OP_SQ_YH: begin mul_a = my_a; mul_b = my_a[MUL_A_W-1:MUL_B_W]; end
            OP_M_AX:  begin mul_a = mx_a; mul_b = semi_x_reg; end
            OP_XOFF:  begin mul_a = my_a; mul_b = semi_y_reg; end
            OP_SM_X:  begin mul_a = MUL_A_W'(dmx_reg); mul_b = MUL_B_W'(gain); end
            OP_SM_Y:  begin mul_a = MUL_A_W'(dmy_reg); mul_b = MUL_B_W'(gain); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb
    begin
        px_next = px_reg;   py_next = py_reg;
        dx_next = dx_reg;   dy_next = dy_reg;
        mx_next = mx_reg;   my_next = my_reg;
        pre_out_next = pre_out_reg;
        p_next = p_reg;     q_next = q_reg;     s_next = s_reg;
        acc_next = acc_reg; acc2_next = acc2_reg;
        sn_next = sn_reg;   res_next = res_reg; sqb_next = sqb_reg;
        r_next = r_reg;
        rem_next = rem_reg; dsh_next = dsh_reg; quo_next = quo_reg;
        clamped_next = clamped_reg;
        inside_next = inside_reg;
        tx_next = tx_reg;   ty_next = ty_reg;
        hx_next = hx_reg;   hy_next = hy_reg;
        negx_next = negx_reg; negy_next = negy_reg;
        dmx_next = dmx_reg; dmy_next = dmy_reg;
        nx_next = nx_reg;   ny_next = ny_reg;
        fx_next = fx_reg;   fy_next = fy_reg;
        ox_next = ox_reg;   oy_next = oy_reg;   oc_next = oc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (op)
            OP_LOAD:
            begin
                px_next = s_tdata[CW-1:0];
                py_next = s_tdata[2*CW-1:CW];
                dx_next = MW'($signed(s_tdata[CW-1:0])) - MW'(center_x_reg);
                dy_next = MW'($signed(s_tdata[2*CW-1:CW])) - MW'(center_y_reg);
            end
            OP_MAG:
            begin
                mx_next = mag_m(dx_reg);
                my_next = mag_m(dy_reg);
            end
            OP_M_PB:  pre_out_next = (mx_reg > MW'(semi_x_reg)) || (my_reg > MW'(semi_y_reg));
            OP_M_QA:  p_next = prod_reg[MUL_A_W-1:0];
            OP_M_AB:  q_next = prod_reg[MUL_A_W-1:0];
            OP_SQ_PL: s_next = prod_reg[MUL_A_W-1:0];
            OP_SQ_PH: acc_next = ACC_W'(prod_reg);
            OP_SQ_QL: acc_next = acc_reg + (ACC_W'(prod_reg) << MUL_B_W);
            OP_SQ_QH: acc_next = acc_reg + ACC_W'(prod_reg);
            OP_SQ_SL: acc_next = acc_reg + (ACC_W'(prod_reg) << MUL_B_W);
            OP_SQ_SH: acc2_next = prod_reg;
            OP_INSIDE:
            begin
                inside_next  = !pre_out_reg && (acc_reg <= s_sq);
                clamped_next = !(!pre_out_reg && (acc_reg <= s_sq));
            end
            OP_TGT_IN:
            begin
                tx_next = px_reg;
                ty_next = py_reg;
            end
            OP_SCALE:
            begin
                mx_next = mx_reg >> 1;
                my_next = my_reg >> 1;
            end
            OP_SQ_XH: acc_next = ACC_W'(prod_reg);
            OP_SQ_YL: acc_next = acc_reg + (ACC_W'(prod_reg) << MUL_B_W);
            OP_SQ_YH: acc_next = acc_reg + ACC_W'(prod_reg);
            OP_N_FIN:
            begin
                sn_next  = SN_W'(acc_reg + (ACC_W'(prod_reg) << MUL_B_W));
                res_next = '0;
                sqb_next = SN_W'(1) << (SN_W - 1);
            end
            OP_SQRT:
            begin
                if (sq_ge)
                begin
                    sn_next  = sn_reg - SN_W'(sq_trial);
                    res_next = (res_reg >> 1) + SQ_W'(sqb_reg);
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                sqb_next = sqb_reg >> 2;
            end
            OP_M_AX:  r_next = (res_reg == '0) ? ROOT_W'(1) : res_reg[ROOT_W-1:0];
            OP_DIV_INIT:
            begin
                rem_next = REM_W'(prod_reg) + REM_W'(r_reg >> 1);
                dsh_next = {r_reg, {MUL_B_W{1'b0}}};
                quo_next = '0;
            end
            OP_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - REM_W'(dsh_reg);
                end
                dsh_next = dsh_reg >> 1;
                quo_next = {quo_reg[QUO_W-2:0], div_ge};
            end
            OP_XOFF:  tx_next = sat_t(tsum_x);
            OP_YOFF:  ty_next = sat_t(tsum_y);
            OP_DEAD:
            begin
                // hold the previous target while both axes sit inside the deadband
                if (!keep)
                begin
                    hx_next = tx_reg;
                    hy_next = ty_reg;
                end
            end
            OP_DIFF:
            begin
                negx_next = dfx[MW-1];
                negy_next = dfy[MW-1];
                dmx_next  = mag_m(dfx);
                dmy_next  = mag_m(dfy);
            end
            OP_SM_Y:  nx_next = nsum_x[CW-1:0];
            OP_SM_N:  ny_next = nsum_y[CW-1:0];
            OP_FINISH:
            begin
                // the new position lies between follower and target, so stays in range
                fx_next = snap_x ? hx_reg : nx_reg;
                fy_next = snap_y ? hy_reg : ny_reg;
                ox_next = snap_x ? hx_reg : nx_reg;
                oy_next = snap_y ? hy_reg : ny_reg;
                oc_next = clamped_reg;
                out_valid_next = 1'b1;
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            semi_x_reg    <= SEMI_X_RST;
            semi_y_reg    <= SEMI_Y_RST;
            alpha_reg     <= ALPHA_RST;
            deadband_reg  <= DB_RST;
            snap_reg      <= SNAP_RST;
            hx_reg        <= '0;
            hy_reg        <= '0;
            fx_reg        <= '0;
            fy_reg        <= '0;
            inside_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hx_reg        <= hx_next;
            hy_reg        <= hy_next;
            fx_reg        <= fx_next;
            fy_reg        <= fy_next;
            inside_reg    <= inside_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CENTER_X: center_x_reg <= cfg_data[CW-1:0];
                    REG_CENTER_Y: center_y_reg <= cfg_data[CW-1:0];
                    REG_SEMI_X:   semi_x_reg   <= cfg_data[SEMI_W-1:0];
                    REG_SEMI_Y:   semi_y_reg   <= cfg_data[SEMI_W-1:0];
                    REG_ALPHA:    alpha_reg    <= cfg_data[ALPHA_W-1:0];
                    REG_DEADBAND: deadband_reg <= cfg_data[DB_W-1:0];
                    REG_SNAP:     snap_reg     <= cfg_data[DB_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;   py_reg <= py_next;
        dx_reg <= dx_next;   dy_reg <= dy_next;
        mx_reg <= mx_next;   my_reg <= my_next;
        pre_out_reg <= pre_out_next;
        p_reg <= p_next;     q_reg <= q_next;     s_reg <= s_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next; acc2_reg <= acc2_next;
        sn_reg <= sn_next;   res_reg <= res_next; sqb_reg <= sqb_next;
        r_reg <= r_next;
        rem_reg <= rem_next; dsh_reg <= dsh_next; quo_reg <= quo_next;
        clamped_reg <= clamped_next;
        tx_reg <= tx_next;   ty_reg <= ty_next;
        negx_reg <= negx_next; negy_reg <= negy_next;
        dmx_reg <= dmx_next; dmy_reg <= dmy_next;
        nx_reg <= nx_next;   ny_reg <= ny_next;
        ox_reg <= ox_next;   oy_reg <= oy_next;   oc_reg <= oc_next;
    end

    assign sts.in_area  = inside_reg;
    assign sts.big      = ((mx_reg >> MAG_LIM) != '0) || ((my_reg >> MAG_LIM) != '0);
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = oc_reg;

    always_comb
    begin
        m_tdata = '0;
        m_tdata[2*CW-1:0] = {oy_reg, ox_reg};
    end

`ifndef SYNTH
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_FINISH |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while still held");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_FINISH |=> m_tvalid)
        else $error("finished item not presented");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_DIV |-> rem_reg < {dsh_reg, 1'b0})
        else $error("division remainder out of bound");

    a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_SQRT |-> $onehot(sqb_reg))
        else $error("square root trial bit lost");
`endif

endmodule

@@ hw/rtl/ellipse_clamped_pointer_smoother.sv @@
// ----------------------------------------------------------------------------
// ellipse_clamped_pointer_smoother
// Pointer follower with elliptic clamp, target deadband and snap.
// ----------------------------------------------------------------------------
// Takes one pointer position per item and returns the new follower position.
// Items are handled one at a time: the input is ready again only once an
// item is finished. An item clamped onto the boundary also runs the 32-step
// square root and the two 21-step restoring divisions on the shared datapath,
// which an item inside the ellipse skips. The result waits in an output
// register, so the next item is taken while it is held.
// tuser carries the clamp flag. Configuration writes take effect at once.
module ellipse_clamped_pointer_smoother
#(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // pointer_x, pointer_y, zero pad
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]           s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // out_x, out_y, zero pad
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]           m_tdata,
    // clamped
    output logic                                         m_tuser,
    input  logic                                         cfg_we,
    input  logic [ecps_pkg::IDX_W-1:0]                   cfg_index,
    input  logic [((COORD_WIDTH > ecps_pkg::SEMI_W) ?
                   COORD_WIDTH : ecps_pkg::SEMI_W)-1:0] cfg_data
);
    import ecps_pkg::*;

    op_t  op;
    sts_t sts;

    ecps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .op       (op)
    );

    ecps_datapath
    #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pointer smoother: random and directed pointer
// items against an in-bench follower model, with ellipse, gain and threshold
// settings changed between phases while the block is idle.
// ----------------------------------------------------------------------------

class follower_scoreboard;
    localparam longint CMAX = (64'sd1 <<< 23) - 1;
    localparam longint CMIN = -CMAX - 1;

    longint ctr_x, ctr_y, semi_a, semi_b, gain, dband, snap_th;
    longint held_x, held_y, pos_x, pos_y;
    logic [23:0] want_x[$];
    logic [23:0] want_y[$];
    bit          want_clamp[$];
    int          errors;
    int          n_clamped;

    function new();
        ctr_x = 0; ctr_y = 0; semi_a = 40 * 256; semi_b = 30 * 256;
        gain = 44657; dband = 128; snap_th = 26;
        held_x = 0; held_y = 0; pos_x = 0; pos_y = 0;
        errors = 0; n_clamped = 0;
    endfunction

    function longint sat(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function longint absv(longint v);
        return v < 0 ? -v : v;
    endfunction

    function longint isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0; b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function longint axis_offset(longint s, longint m, longint r, bit neg);
        longint q;
        q = (s * m + r / 2) / r;
        if (q > s) q = s;
        return neg ? -q : q;
    endfunction

    function longint step_axis(longint p, longint t, longint g);
        longint d, s, n;
        d = t - p;
        s = (absv(d) * g + 32768) >>> 16;
        n = d < 0 ? p - s : p + s;
        if (absv(t - n) < snap_th) n = t;
        return sat(n);
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] v);
        case (idx)
            ecps_pkg::REG_CENTER_X: ctr_x = longint'($signed(v));
            ecps_pkg::REG_CENTER_Y: ctr_y = longint'($signed(v));
            ecps_pkg::REG_SEMI_X:   semi_a = v[19:0];
            ecps_pkg::REG_SEMI_Y:   semi_b = v[19:0];
            ecps_pkg::REG_ALPHA:    gain = v[16:0];
            ecps_pkg::REG_DEADBAND: dband = v[15:0];
            ecps_pkg::REG_SNAP:     snap_th = v[15:0];
            default: ;
        endcase
    endfunction

    function void note_pointer(logic [23:0] px_b, logic [23:0] py_b);
        longint px, py, dx, dy, mx, my, tx, ty, r, g;
        logic [127:0] lhs, rhs;
        bit in_ell;
        px = longint'($signed(px_b)); py = longint'($signed(py_b));
        dx = px - ctr_x; dy = py - ctr_y;
        mx = absv(dx); my = absv(dy);
        g = gain > 65536 ? 65536 : gain;
        in_ell = 0;
        if (mx <= semi_a && my <= semi_b)
        begin
            lhs = 128'(mx * semi_b) * 128'(mx * semi_b) + 128'(my * semi_a) * 128'(my * semi_a);
            rhs = 128'(semi_a * semi_b) * 128'(semi_a * semi_b);
            in_ell = lhs <= rhs;
        end
        if (in_ell)
        begin
            tx = px; ty = py;
        end
        else
        begin
            while (mx >= (64'sd1 <<< 31) || my >= (64'sd1 <<< 31))
            begin
                mx >>>= 1; my >>>= 1;
            end
            r = isqrt(mx * mx + my * my);
            if (r == 0) r = 1;
            tx = sat(ctr_x + axis_offset(semi_a, mx, r, dx < 0));
            ty = sat(ctr_y + axis_offset(semi_b, my, r, dy < 0));
            n_clamped++;
        end
        if (absv(tx - held_x) < dband && absv(ty - held_y) < dband)
        begin
            tx = held_x; ty = held_y;
        end
        held_x = tx; held_y = ty;
        pos_x = step_axis(pos_x, tx, g);
        pos_y = step_axis(pos_y, ty, g);
        want_x.push_back(pos_x[23:0]);
        want_y.push_back(pos_y[23:0]);
        want_clamp.push_back(!in_ell);
    endfunction

    function void report(string what, longint got, longint exp);
        $display("mismatch %s: got %0h expected %0h", what, got, exp);
        errors++;
    endfunction

    function void check_result(logic [47:0] d, logic clamp);
        if (want_x.size() == 0)
        begin
            report("unexpected item", d, 0);
            return;
        end
        if (d[23:0] !== want_x[0]) report("out_x", d[23:0], want_x[0]);
        if (d[47:24] !== want_y[0]) report("out_y", d[47:24], want_y[0]);
        if (clamp !== want_clamp[0]) report("clamped", clamp, want_clamp[0]);
        void'(want_x.pop_front());
        void'(want_y.pop_front());
        void'(want_clamp.pop_front());
    endfunction
endclass

module tb;
    import ecps_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    follower_scoreboard sb;
    bit  calm;
    int  stall_cycles;
    int  n_items;

    ellipse_clamped_pointer_smoother dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // sample results and count idle cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles > 20000)
            begin
                $display("watchdog expired");
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            m_tready <= 1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] v);
        @(negedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, v);
    endtask

    // tvalid stays up between items sent back to back; drain drops it
    task automatic send_pointer(logic [23:0] px, logic [23:0] py);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {py, px};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_pointer(px, py);
        n_items++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.want_x.size() != 0) @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    function automatic logic [23:0] near_value(longint c, int span);
        return 24'(c + $signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_phase(int count);
        longint cx, cy;
        int sp;
        cx = sb.ctr_x; cy = sb.ctr_y;
        sp = int'(sb.semi_a > sb.semi_b ? sb.semi_a : sb.semi_b) * 2 + 64;
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0, 1: send_pointer(24'($urandom), 24'($urandom));
                2:    send_pointer(near_value(sb.held_x, 200), near_value(sb.held_y, 200));
                default: send_pointer(near_value(cx, sp), near_value(cy, sp));
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        calm = 0; n_items = 0;
        rst_n = 0; s_tvalid = 0; s_tdata = '0;
        cfg_we = 0; cfg_index = REG_CENTER_X; cfg_data = '0;
        repeat (4) @(negedge clk);
        rst_n = 1;

        // directed: field extremes, centre, boundary points, degenerate ones
        send_pointer(24'h0, 24'h0);
        send_pointer(24'h7FFFFF, 24'h7FFFFF);
        send_pointer(24'h800000, 24'h800000);
        send_pointer(24'h7FFFFF, 24'h800000);
        send_pointer(24'h800000, 24'h7FFFFF);
        send_pointer(24'd10240, 24'd0);
        send_pointer(24'd0, 24'd7680);
        send_pointer(24'd10241, 24'd0);
        send_pointer(-24'sd10240, 24'd0);
        send_pointer(24'd20, 24'd20);
        send_pointer(24'd30, 24'd10);
        send_pointer(24'h555555, 24'hAAAAAA);
        send_pointer(24'hAAAAAA, 24'h555555);
        drain();
        // degenerate ellipse: zero semi axes, no deadband or snap, gain beyond one
        write_reg(REG_SEMI_X, 24'd0);
        write_reg(REG_SEMI_Y, 24'd0);
        write_reg(REG_DEADBAND, 24'd0);
        write_reg(REG_SNAP, 24'd0);
        write_reg(REG_ALPHA, 24'h1FFFF);
        send_pointer(24'd0, 24'd0);
        send_pointer(24'd500, 24'd0);
        send_pointer(24'h7FFFFF, 24'h800000);
        drain();
        write_reg(REG_SEMI_X, 24'hFFFFF);
        write_reg(REG_SEMI_Y, 24'd1);
        write_reg(REG_ALPHA, 24'd0);
        write_reg(REG_CENTER_X, 24'h7FFFFF);
        write_reg(REG_CENTER_Y, 24'h800000);
        send_pointer(24'h800000, 24'h7FFFFF);
        send_pointer(24'h7FFFFF, 24'h800000);
        drain();
        write_reg(3'd7, 24'h123456);

        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(REG_CENTER_X,
                      $urandom_range(0, 3) == 0 ? 24'($urandom) : near_value(0, 5000));
            write_reg(REG_CENTER_Y,
                      $urandom_range(0, 3) == 0 ? 24'($urandom) : near_value(0, 5000));
            write_reg(REG_SEMI_X, ph == 0 ? 24'hFFFFF : 24'($urandom_range(1, 40000)));
            write_reg(REG_SEMI_Y, ph == 1 ? 24'hFFFFF : 24'($urandom_range(1, 40000)));
            write_reg(REG_ALPHA, ph == 2 ? 24'd65536 : 24'($urandom_range(0, 70000)));
            write_reg(REG_DEADBAND, ph == 3 ? 24'hFFFF : 24'($urandom_range(0, 400)));
            write_reg(REG_SNAP, ph == 4 ? 24'hFFFF : 24'($urandom_range(0, 100)));
            if (ph == 6) calm = 1;
            random_phase(245);
            drain();
        end

        $display("items sent: %0d, clamped onto the ellipse: %0d", n_items, sb.n_clamped);
        $display("covered register extremes, degenerate axes, saturation and stalls");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/ecps_pkg.sv
hw/rtl/ecps_ctrl.sv
hw/rtl/ecps_datapath.sv
hw/rtl/ellipse_clamped_pointer_smoother.sv
tb/sv/tb.sv
